// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define PMBL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pmbl assertion failed");

// Next-cycle implication, ignored while reset is held.
`define PMBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pmbl assertion failed");

// Next-cycle implication that is also checked across reset.
`define PMBL_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pmbl assertion failed");

`endif

// ----- src/pmbl_pkg.sv -----
// Shared types, constants and reciprocal tables of the metadata bit locator.
package pmbl_pkg;

    localparam int unsigned M_W       = 5;
    localparam int unsigned BLEN_W    = 13;
    localparam int unsigned POS_W     = 17;
    localparam int unsigned OFF_W     = 12;
    localparam int unsigned MASK_W    = 24;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 13;

    localparam logic [BLEN_W-1:0] MAX_BLOCK_SAMPLES = 13'd4096;
    localparam logic [M_W-1:0]    M_MIN             = 5'd3;
    localparam logic [M_W-1:0]    M_MAX             = 5'd24;
    localparam logic [M_W-1:0]    M_RESET           = 5'd3;
    localparam logic [BLEN_W-1:0] BLEN_RESET        = 13'd4096;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SUB_SAMPLE_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH    = 1'b1;

    // Reciprocal scaling: quotient = (n * rec) >> shift, exact over the used ranges.
    localparam int unsigned CYC_SHIFT = 26;
    localparam int unsigned CYC_REC_W = 21;
    localparam int unsigned DIV_SHIFT = 23;
    localparam int unsigned DIV_REC_W = 24;

    typedef struct packed {
        logic [M_W-1:0]       m;
        logic                 m_ok;
        logic [BLEN_W-1:0]    blen_eff;
        logic [CYC_REC_W-1:0] rec_cyc;
    } cfg_t;

    // ceil(2^26 / (16m - 1)) for the supported factors.
    function automatic logic [CYC_REC_W-1:0] rec_cyc_f(input logic [M_W-1:0] m);
        logic [CYC_REC_W-1:0] r;
        case (m)
            5'd3:    r = 21'd1427849;
            5'd4:    r = 21'd1065221;
            5'd5:    r = 21'd849480;
            5'd6:    r = 21'd706410;
            5'd7:    r = 21'd604585;
            5'd8:    r = 21'd528417;
            5'd9:    r = 21'd469293;
            5'd10:   r = 21'd422069;
            5'd11:   r = 21'd383480;
            5'd12:   r = 21'd351356;
            5'd13:   r = 21'd324198;
            5'd14:   r = 21'd300937;
            5'd15:   r = 21'd280791;
            5'd16:   r = 21'd263173;
            5'd17:   r = 21'd247635;
            5'd18:   r = 21'd233829;
            5'd19:   r = 21'd221482;
            5'd20:   r = 21'd210373;
            5'd21:   r = 21'd200325;
            5'd22:   r = 21'd191194;
            5'd23:   r = 21'd182858;
            5'd24:   r = 21'd175219;
            default: r = '0;
        endcase
        return r;
    endfunction

    // ceil(2^23 / d) for divisors 1 to 24.
    function automatic logic [DIV_REC_W-1:0] rec_div_f(input logic [M_W-1:0] d);
        logic [DIV_REC_W-1:0] r;
        case (d)
            5'd1:    r = 24'd8388608;
            5'd2:    r = 24'd4194304;
            5'd3:    r = 24'd2796203;
            5'd4:    r = 24'd2097152;
            5'd5:    r = 24'd1677722;
            5'd6:    r = 24'd1398102;
            5'd7:    r = 24'd1198373;
            5'd8:    r = 24'd1048576;
            5'd9:    r = 24'd932068;
            5'd10:   r = 24'd838861;
            5'd11:   r = 24'd762601;
            5'd12:   r = 24'd699051;
            5'd13:   r = 24'd645278;
            5'd14:   r = 24'd599187;
            5'd15:   r = 24'd559241;
            5'd16:   r = 24'd524288;
            5'd17:   r = 24'd493448;
            5'd18:   r = 24'd466034;
            5'd19:   r = 24'd441506;
            5'd20:   r = 24'd419431;
            5'd21:   r = 24'd399458;
            5'd22:   r = 24'd381301;
            5'd23:   r = 24'd364723;
            5'd24:   r = 24'd349526;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/pmbl_cfg.sv -----
// Configuration registers of the bit locator and the constants derived from them.
module pmbl_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pmbl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmbl_pkg::CFG_DAT_W-1:0]      cfg_wdata,
    output pmbl_pkg::cfg_t                      cfg
);
    import pmbl_pkg::*;

    logic [M_W-1:0]    m_reg;
    logic [M_W-1:0]    m_next;
    logic [BLEN_W-1:0] blen_reg;
    logic [BLEN_W-1:0] blen_next;

    always_comb begin
        m_next    = m_reg;
        blen_next = blen_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_SUB_SAMPLE_BITS: m_next    = cfg_wdata[M_W-1:0];
                REG_BLOCK_LENGTH:    blen_next = cfg_wdata[BLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_reg    <= M_RESET;
            blen_reg <= BLEN_RESET;
        end else begin
            m_reg    <= m_next;
            blen_reg <= blen_next;
        end
    end

    always_comb begin
        cfg.m        = m_reg;
        cfg.m_ok     = (m_reg >= M_MIN) && (m_reg <= M_MAX);
        cfg.blen_eff = (blen_reg > MAX_BLOCK_SAMPLES) ? MAX_BLOCK_SAMPLES : blen_reg;
        cfg.rec_cyc  = rec_cyc_f(m_reg);
    end

endmodule

// ----- src/pcm_metadata_bit_locator_core.sv -----
// Top level of the PCM metadata bit locator: request stream in, location stream out.
//
// One request is accepted per clock cycle while m_tready does not stall the pipeline, and its
// location passes through the stage registers into the output register. The six stages are set by two dependent
// divisions done as reciprocal multiplications: stage one sorts the position into its
// region, stage two multiplies by the reciprocal of the projector cycle, stage three adds
// the skipped positions, stage four multiplies by the reciprocal of the divisor, stage five
// forms the quotient times the divisor and stage six takes the remainder into a bit mask
// and checks the offset against the block length. Each stage holds its request only while
// the stage after it is full and stalled, so bubbles close up under back-pressure.
// Configuration writes take effect on the next cycle.
module pcm_metadata_bit_locator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pmbl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmbl_pkg::CFG_DAT_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // meta_bit_idx[16:0], zero fill
    input  logic                                s_tuser,   // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,   // sample_idx[11:0],
                                                           // carry_mask[35:12], zero fill
    output logic                                m_tuser    // location_valid
);
    import pmbl_pkg::*;

    localparam int unsigned NSTAGE = 6;
    localparam int unsigned P1_W   = POS_W + CYC_REC_W;
    localparam int unsigned Q1_W   = 12;
    localparam int unsigned ADJ_W  = 18;
    localparam int unsigned P2_W   = ADJ_W + DIV_REC_W;
    localparam int unsigned Q2_W   = P2_W - DIV_SHIFT;

    typedef enum logic [2:0] {
        RG_BIT0,
        RG_BIT1,
        RG_BIT2,
        RG_MID,
        RG_HIGH
    } region_t;

    typedef struct packed {
        logic             inv;
        region_t          region;
        logic [3:0]       small_off;
    } ctl_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] n1;
    } st1_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [POS_W-1:0] pos;
        logic [P1_W-1:0]  p1;
    } st2_t;

    typedef struct packed {
        ctl_t               ctl;
        logic [ADJ_W-1:0]   adj;
        logic [M_W-1:0]     d2;
        logic [DIV_REC_W-1:0] rec2;
    } st3_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [ADJ_W-1:0] adj;
        logic [M_W-1:0]   d2;
        logic [P2_W-1:0]  p2;
    } st4_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [ADJ_W-1:0] adj;
        logic [Q2_W-1:0]  q2;
        logic [ADJ_W-1:0] t;
    } st5_t;

    typedef struct packed {
        logic              location_valid;
        logic [OFF_W-1:0]  sample_idx;
        logic [MASK_W-1:0] carry_mask;
    } res_t;

    cfg_t cfg;

    pmbl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] rdy;

    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    st5_t st5_reg, st5_next;
    res_t res_reg, res_next;

    // A stage may load when it is empty or when its content moves on.
    always_comb begin
        rdy[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: classify the position and prepare the projector-cycle numerator.
    always_comb begin
        logic [POS_W-1:0] pos;
        logic             typ;
        logic [POS_W-1:0] m_ext;
        logic [POS_W-1:0] m16;
        pos   = s_tdata[POS_W-1:0];
        typ   = s_tuser;
        m_ext = POS_W'(cfg.m);
        m16   = POS_W'({cfg.m, 4'b0000});
        st1_next.pos           = pos;
        st1_next.ctl.small_off = pos[3:0];
        st1_next.ctl.inv       = !cfg.m_ok || (typ && (pos < m_ext));
        if (pos > 17'd47) begin
            st1_next.ctl.region = (pos < m16) ? RG_MID : RG_HIGH;
        end else if (pos >= 17'd32) begin
            st1_next.ctl.region = RG_BIT2;
        end else if (pos >= 17'd16) begin
            st1_next.ctl.region = RG_BIT1;
        end else begin
            st1_next.ctl.region = RG_BIT0;
        end
        // Only requests of type 1 in the high region skip projector-cycle positions.
        if (typ && (st1_next.ctl.region == RG_HIGH)) begin
            st1_next.n1 = pos - m_ext;
        end else begin
            st1_next.n1 = '0;
        end
    end

    // Stage 2: multiply by the reciprocal of the projector cycle length.
    always_comb begin
        st2_next.ctl = st1_reg.ctl;
        st2_next.pos = st1_reg.pos;
        st2_next.p1  = P1_W'(st1_reg.n1) * P1_W'(cfg.rec_cyc);
    end

    // Stage 3: adjusted position, divisor and its reciprocal.
    always_comb begin
        logic [Q1_W-1:0] q1;
        q1 = Q1_W'(st2_reg.p1 >> CYC_SHIFT);
        st3_next.ctl = st2_reg.ctl;
        if (st2_reg.ctl.region == RG_MID) begin
            st3_next.adj = ADJ_W'(st2_reg.pos) - 18'd48;
            st3_next.d2  = cfg.m - 5'd3;
        end else begin
            st3_next.adj = ADJ_W'(st2_reg.pos) + ADJ_W'(q1);
            st3_next.d2  = cfg.m;
        end
        st3_next.rec2 = rec_div_f(st3_next.d2);
    end

    // Stage 4: multiply by the reciprocal of the divisor.
    always_comb begin
        st4_next.ctl = st3_reg.ctl;
        st4_next.adj = st3_reg.adj;
        st4_next.d2  = st3_reg.d2;
        st4_next.p2  = P2_W'(st3_reg.adj) * P2_W'(st3_reg.rec2);
    end

    // Stage 5: quotient and quotient times divisor.
    always_comb begin
        logic [Q2_W-1:0] q2;
        q2 = Q2_W'(st4_reg.p2 >> DIV_SHIFT);
        st5_next.ctl = st4_reg.ctl;
        st5_next.adj = st4_reg.adj;
        st5_next.q2  = q2;
        // The product never exceeds the adjusted position.
        st5_next.t   = ADJ_W'(q2 * Q2_W'(st4_reg.d2));
    end

    // Stage 6: remainder to mask, offset check against the block.
    always_comb begin
        logic [M_W-1:0]    rem;
        logic [M_W-1:0]    sh;
        logic [Q2_W-1:0]   off;
        logic [MASK_W-1:0] mask;
        rem = M_W'(st5_reg.adj - st5_reg.t);
        sh  = cfg.m - 5'd1 - rem;
        case (st5_reg.ctl.region)
            RG_BIT0: begin
                off  = Q2_W'(st5_reg.ctl.small_off);
                mask = 24'd1;
            end
            RG_BIT1: begin
                off  = Q2_W'(st5_reg.ctl.small_off);
                mask = 24'd2;
            end
            RG_BIT2: begin
                off  = Q2_W'(st5_reg.ctl.small_off);
                mask = 24'd4;
            end
            RG_MID, RG_HIGH: begin
                off  = st5_reg.q2;
                mask = 24'd1 << sh;
            end
            default: begin
                off  = '0;
                mask = '0;
            end
        endcase
        res_next.location_valid = !st5_reg.ctl.inv && (off < Q2_W'(cfg.blen_eff));
        res_next.sample_idx     = res_next.location_valid ? off[OFF_W-1:0] : '0;
        res_next.carry_mask     = res_next.location_valid ? mask : '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) st1_reg <= st1_next;
        if (rdy[1]) st2_reg <= st2_next;
        if (rdy[2]) st3_reg <= st3_next;
        if (rdy[3]) st4_reg <= st4_next;
        if (rdy[4]) st5_reg <= st5_next;
        if (rdy[5]) res_reg <= res_next;
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTAGE-1];
    assign m_tuser  = res_reg.location_valid;
    assign m_tdata  = {4'b0000, res_reg.carry_mask, res_reg.sample_idx};

endmodule

// ----- src/pmbl_checker.sv -----
// Port-level checks of the bit locator, attached to the top level by bind.
`include "assert_macros.svh"

module pmbl_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [39:0]                         m_tdata,
    input logic                                m_tuser
);

    // A stalled result keeps its value until it is taken.
    `PMBL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A rejected location carries no offset and no mask.
    `PMBL_ASSERT_NOW(a_invalid_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == 40'd0)

    // An accepted location marks exactly one carrying bit.
    `PMBL_ASSERT_NOW(a_mask_onehot, aclk, aresetn, m_tvalid && m_tuser, $onehot(m_tdata[35:12]))

    // Reset empties the pipeline.
    `PMBL_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind pcm_metadata_bit_locator_core pmbl_checker u_pmbl_checker (.*);
